// ===== rtl/asp_pkg.sv =====
// ----------------------------------------------------------------------------
// asp_pkg
// Shared types, character codes and helper functions of the ASCII to
// unsigned integer parser.
// ----------------------------------------------------------------------------
package asp_pkg;

  // Default widths
  localparam int unsigned VALUE_BITS_DEF  = 64;
  localparam int unsigned OFFSET_BITS_DEF = 16;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned RADIX_W = 6;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UB    = 8'h42;
  localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
  localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LB    = 8'h62;
  localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
  localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;

  // Base codes
  localparam logic [RADIX_W-1:0] RADIX_AUTO = 6'd0;
  localparam logic [RADIX_W-1:0] BASE_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] BASE_BIN   = 6'd2;
  localparam logic [RADIX_W-1:0] BASE_OCT   = 6'd8;
  localparam logic [RADIX_W-1:0] BASE_DEC   = 6'd10;
  localparam logic [RADIX_W-1:0] BASE_HEX   = 6'd16;
  localparam logic [RADIX_W-1:0] BASE_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] NO_DIGIT   = 6'd36;
  localparam logic [CHAR_W-1:0]  LETTER_OFS = 8'd10;

  // Parser phase
  typedef enum logic [2:0] {
    PH_WS     = 3'd0,
    PH_SIGNED = 3'd1,
    PH_ZERO   = 3'd2,
    PH_PREFIX = 3'd3,
    PH_DIGITS = 3'd4,
    PH_SKIP   = 3'd5
  } phase_e;

  // Status of one processed character
  typedef struct packed {
    logic emit;
    logic overflow;
  } step_status_t;

  // Digit value of a character, NO_DIGIT where it is no digit at all
  function automatic logic [RADIX_W-1:0] digit_value(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] t;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      t = c - CH_ZERO;
    end else if (c >= CH_LA && c <= CH_LZ) begin
      t = c - CH_LA + LETTER_OFS;
    end else if (c >= CH_UA && c <= CH_UZ) begin
      t = c - CH_UA + LETTER_OFS;
    end else begin
      t = {2'b00, NO_DIGIT};
    end
    return t[RADIX_W-1:0];
  endfunction

  // Base forced into the range 2 to 36
  function automatic logic [RADIX_W-1:0] clamp_base(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] b;
    if (r < BASE_MIN) begin
      b = BASE_MIN;
    end else if (r > BASE_MAX) begin
      b = BASE_MAX;
    end else begin
      b = r;
    end
    return b;
  endfunction

endpackage

// ===== rtl/ascii_to_unsigned_parser.sv =====
// ----------------------------------------------------------------------------
// ascii_to_unsigned_parser
// Stream parser that turns ASCII characters into an unsigned integer in the
// manner of strtoul.
// ----------------------------------------------------------------------------
// One character is taken per cycle, back to back, with no bubbles while the
// output side keeps up. Each character sits in an input register, where the
// parser logic (one multiply-accumulate by the base) decides the next state; a
// character that ends the number loads the result register from the input
// register, so tvalid is driven by the result register. The character waits in
// the input register while the result register is full and stalled.
// Write the radix register (0 selects the base from a 0b, 0x or 0 prefix) only
// while no string is being parsed. Result tdata carries value, end offset and
// overflow flag; there is no reset sweep and no start-up delay.
module ascii_to_unsigned_parser import asp_pkg::*; #(
  parameter int unsigned VALUE_BITS  = VALUE_BITS_DEF,
  parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF,
  localparam int unsigned OUT_W      = ((VALUE_BITS + OFFSET_BITS + 1 + 7) / 8) * 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [RADIX_W-1:0] cfg_wdata_i,
  // character input
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [CHAR_W-1:0]  s_axis_tdata_i,  // [7:0] char_code
  // result output
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [OUT_W-1:0]   m_axis_tdata_o   // value, end_offset, overflow, zero pad
);

  localparam int unsigned PAD_W = OUT_W - VALUE_BITS - OFFSET_BITS - 1;

  logic [RADIX_W-1:0]     radix_q;
  logic                   in_valid_q;
  logic [CHAR_W-1:0]      in_char_q;
  logic                   out_valid_q;
  logic [VALUE_BITS-1:0]  out_value_q;
  logic [OFFSET_BITS-1:0] out_offset_q;
  logic                   out_ovf_q;
  logic                   fire;
  step_status_t           status;
  logic [VALUE_BITS-1:0]  step_value;
  logic [OFFSET_BITS-1:0] step_offset;

  // Process the held character when the result register can take a result
  assign fire            = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || fire;

  // Radix register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_AUTO;
    end else if (cfg_we_i) begin
      radix_q <= cfg_wdata_i;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_char_q <= s_axis_tdata_i;
    end
  end

  asp_step #(
    .VALUE_BITS (VALUE_BITS),
    .OFFSET_BITS(OFFSET_BITS)
  ) u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .char_i      (in_char_q),
    .radix_i     (radix_q),
    .status_o    (status),
    .value_o     (step_value),
    .end_offset_o(step_offset)
  );

  // Result register: load on a result, drop once the transaction completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && status.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && status.emit) begin
      out_value_q  <= step_value;
      out_offset_q <= step_offset;
      out_ovf_q    <= status.overflow;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{PAD_W{1'b0}}, out_ovf_q, out_offset_q, out_value_q};

endmodule

// ===== rtl/asp_mac.sv =====
// ----------------------------------------------------------------------------
// asp_mac
// Multiply-accumulate of one digit into the running value, with a flag
// when the result no longer fits in VALUE_BITS bits.
// ----------------------------------------------------------------------------
module asp_mac import asp_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic [VALUE_BITS-1:0] acc_i,
  input  logic [RADIX_W-1:0]    base_i,
  input  logic [RADIX_W-1:0]    digit_i,
  output logic [VALUE_BITS-1:0] sum_o,
  output logic                  ovf_o
);

  localparam int unsigned WIDE_W = VALUE_BITS + RADIX_W;

  logic [WIDE_W-1:0] wide;

  // acc * base + digit stays below 64 * 2^VALUE_BITS for any base up to 36
  assign wide  = WIDE_W'(acc_i) * WIDE_W'(base_i) + WIDE_W'(digit_i);
  assign sum_o = wide[VALUE_BITS-1:0];
  assign ovf_o = |wide[WIDE_W-1:VALUE_BITS];

endmodule

// ===== rtl/asp_step.sv =====
// ----------------------------------------------------------------------------
// asp_step
// Parser state and the single-pass next-state logic for one character:
// whitespace, sign, prefix detection, digit accumulation and overflow skip.
// ----------------------------------------------------------------------------
module asp_step import asp_pkg::*; #(
  parameter int unsigned VALUE_BITS  = VALUE_BITS_DEF,
  parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   fire_i,
  input  logic [CHAR_W-1:0]      char_i,
  input  logic [RADIX_W-1:0]     radix_i,
  output step_status_t           status_o,
  output logic [VALUE_BITS-1:0]  value_o,
  output logic [OFFSET_BITS-1:0] end_offset_o
);

  localparam int unsigned        SUM_W   = OFFSET_BITS + 2;
  localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};
  localparam logic [VALUE_BITS-1:0]  VAL_MAX = {VALUE_BITS{1'b1}};

  phase_e                 phase_q, phase_d;
  logic [VALUE_BITS-1:0]  acc_q, acc_d;
  logic                   neg_q, neg_d;
  logic [RADIX_W-1:0]     base_q, base_d;
  logic [OFFSET_BITS-1:0] off_q, off_d;

  logic [RADIX_W-1:0]     dv, r_clamp, ds_base;
  logic                   is_ws, zero_ok, ds_digit, do_ds, ds_two;
  logic [SUM_W-1:0]       off_sum1, off_sum2;
  logic [OFFSET_BITS-1:0] off_inc1, off_inc2;
  logic [VALUE_BITS-1:0]  mac_sum;
  logic                   mac_ovf;

  // Character classification
  assign dv      = digit_value(char_i);
  assign r_clamp = clamp_base(radix_i);
  assign is_ws   = (char_i == CH_SPACE) || (char_i >= CH_TAB && char_i <= CH_CR);
  assign zero_ok = (char_i == CH_ZERO) &&
                   (radix_i == RADIX_AUTO || radix_i == BASE_BIN || radix_i == BASE_HEX);

  // Base of a digit taken in this phase
  always_comb begin
    unique case (phase_q)
      PH_ZERO:                      ds_base = (radix_i == RADIX_AUTO) ? BASE_OCT : r_clamp;
      PH_PREFIX, PH_DIGITS, PH_SKIP: ds_base = base_q;
      default:                      ds_base = (radix_i == RADIX_AUTO) ? BASE_DEC : r_clamp;
    endcase
  end

  assign ds_digit = dv < ds_base;

  // Saturating offset advance by one and by two
  assign off_sum1 = SUM_W'(off_q) + SUM_W'(1);
  assign off_sum2 = SUM_W'(off_q) + SUM_W'(2);
  assign off_inc1 = (off_sum1 > SUM_W'(OFF_MAX)) ? OFF_MAX : off_sum1[OFFSET_BITS-1:0];
  assign off_inc2 = (off_sum2 > SUM_W'(OFF_MAX)) ? OFF_MAX : off_sum2[OFFSET_BITS-1:0];

  asp_mac #(
    .VALUE_BITS(VALUE_BITS)
  ) u_mac (
    .acc_i  (acc_q),
    .base_i (ds_base),
    .digit_i(dv),
    .sum_o  (mac_sum),
    .ovf_o  (mac_ovf)
  );

  // Next state and result
  always_comb begin
    phase_d      = phase_q;
    acc_d        = acc_q;
    neg_d        = neg_q;
    base_d       = base_q;
    off_d        = off_q;
    status_o     = '0;
    value_o      = '0;
    end_offset_o = '0;
    do_ds        = 1'b0;
    ds_two       = 1'b0;

    unique case (phase_q)
      PH_ZERO: begin
        if ((char_i == CH_LB || char_i == CH_UB) &&
            (radix_i == RADIX_AUTO || radix_i == BASE_BIN)) begin
          base_d  = BASE_BIN;
          phase_d = PH_PREFIX;
        end else if ((char_i == CH_LX || char_i == CH_UX) &&
                     (radix_i == RADIX_AUTO || radix_i == BASE_HEX)) begin
          base_d  = BASE_HEX;
          phase_d = PH_PREFIX;
        end else begin
          do_ds = 1'b1;
        end
      end
      PH_PREFIX: begin
        if (!ds_digit) begin
          status_o.emit = 1'b1;
          end_offset_o  = off_q;
        end else begin
          do_ds  = 1'b1;
          ds_two = 1'b1;
        end
      end
      PH_DIGITS: begin
        do_ds = 1'b1;
      end
      PH_SKIP: begin
        if (ds_digit) begin
          off_d = off_inc1;
        end else begin
          status_o.emit     = 1'b1;
          status_o.overflow = 1'b1;
          value_o           = VAL_MAX;
          end_offset_o      = off_q;
        end
      end
      default: begin
        // Whitespace and sign only before the first character of the number
        if (phase_q != PH_SIGNED && is_ws) begin
          off_d = off_inc1;
        end else if (phase_q != PH_SIGNED && (char_i == CH_MINUS || char_i == CH_PLUS)) begin
          neg_d   = (char_i == CH_MINUS);
          phase_d = PH_SIGNED;
          off_d   = off_inc1;
        end else if (zero_ok) begin
          acc_d   = '0;
          phase_d = PH_ZERO;
          off_d   = off_inc1;
        end else if (!ds_digit) begin
          status_o.emit = 1'b1;
        end else begin
          do_ds = 1'b1;
        end
      end
    endcase

    // Take one digit, or close the run on a non-digit
    if (do_ds) begin
      base_d = ds_base;
      if (!ds_digit) begin
        status_o.emit = 1'b1;
        value_o       = neg_q ? (VALUE_BITS'(0) - acc_q) : acc_q;
        end_offset_o  = off_q;
      end else begin
        off_d = ds_two ? off_inc2 : off_inc1;
        if (mac_ovf) begin
          acc_d   = VAL_MAX;
          phase_d = PH_SKIP;
        end else begin
          acc_d   = mac_sum;
          phase_d = PH_DIGITS;
        end
      end
    end

    // Start a new string after a result
    if (status_o.emit) begin
      phase_d = PH_WS;
      acc_d   = '0;
      neg_d   = 1'b0;
      base_d  = '0;
      off_d   = '0;
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WS;
      acc_q   <= '0;
      neg_q   <= 1'b0;
      base_q  <= '0;
      off_q   <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      neg_q   <= neg_d;
      base_q  <= base_d;
      off_q   <= off_d;
    end
  end

endmodule

// ===== rtl/asp_checker.sv =====
// ----------------------------------------------------------------------------
// asp_checker
// Port-level checks of the parser, bound to the top level.
// ----------------------------------------------------------------------------
module asp_checker import asp_pkg::*; #(
  parameter int unsigned VALUE_BITS  = VALUE_BITS_DEF,
  parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF,
  localparam int unsigned OUT_W      = ((VALUE_BITS + OFFSET_BITS + 1 + 7) / 8) * 8
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tready_o,
  input logic               m_axis_tvalid_o,
  input logic               m_axis_tready_i,
  input logic [OUT_W-1:0]   m_axis_tdata_o
);

  localparam int unsigned OVF_BIT = VALUE_BITS + OFFSET_BITS;

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // Input stalls only behind a full, stalled result register
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled without output back-pressure");

  // Overflow saturates the value
  a_ovf_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[OVF_BIT] |->
      m_axis_tdata_o[VALUE_BITS-1:0] == {VALUE_BITS{1'b1}} &&
      m_axis_tdata_o[OVF_BIT-1:VALUE_BITS] != '0)
    else $error("overflow result without saturated value or offset");

  // No character consumed means value zero
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[OVF_BIT-1:VALUE_BITS] == '0 |->
      m_axis_tdata_o[VALUE_BITS-1:0] == '0 && !m_axis_tdata_o[OVF_BIT])
    else $error("non-zero result at offset zero");

endmodule

bind ascii_to_unsigned_parser asp_checker #(
  .VALUE_BITS (VALUE_BITS),
  .OFFSET_BITS(OFFSET_BITS)
) u_asp_checker (.*);
